// ===== rtl/spvns_pkg.sv =====
// Package for the SPIR-V non-uniform stripper: payload types, opcodes, name table.
`default_nettype none
package spvns_pkg;

  localparam int HEADER_WORDS_DEF  = 5;
  localparam int PENDING_DEPTH_DEF = 8;

  localparam logic [15:0] OP_EXTENSION       = 16'd10;
  localparam logic [15:0] OP_CAPABILITY      = 16'd17;
  localparam logic [15:0] OP_DECORATE        = 16'd71;
  localparam logic [15:0] OP_MEMBER_DECORATE = 16'd72;
  localparam logic [15:0] OP_DECORATE_ID     = 16'd332;

  localparam logic [31:0] DECOR_NONUNIFORM = 32'd5300;
  localparam logic [31:0] CAP_FIRST        = 32'd5301;
  localparam logic [31:0] CAP_LAST         = 32'd5312;

  localparam logic [15:0] EXT_INST_WORDS = 16'd8;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } item_t;

  typedef struct packed {
    logic [31:0] out_word;
    logic        has_word;
    logic        end_of_module;
  } result_t;

  typedef enum logic [2:0] {
    DEC_UNDECIDED = 3'b001,
    DEC_KEEP      = 3'b010,
    DEC_DROP      = 3'b100
  } decision_t;

  // stripped extension name packed little-endian, NUL in the last byte
  function automatic logic [31:0] ext_name_word(input logic [2:0] idx);
    logic [31:0] w;
    case (idx)
      3'd0: w = 32'h5F565053;
      3'd1: w = 32'h5F545845;
      3'd2: w = 32'h63736564;
      3'd3: w = 32'h74706972;
      3'd4: w = 32'h695F726F;
      3'd5: w = 32'h7865646E;
      3'd6: w = 32'h00676E69;
      default: w = 32'h00000000;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/spirv_nonuniform_stripper_top.sv =====
// Top level of the SPIR-V non-uniform stripper: instruction filter and output ring.
//
//  channel  | signals                              | payload
//  ---------+--------------------------------------+------------------------------
//  item     | item_valid, item_ready, item         | word, last
//  result   | result_valid, result_ready, result   | out_word, has_word, end_of_module
//
// One word is accepted per cycle while the ring has room; its keep/drop step is combinational compare logic.
// Words are written into a ring and released one per cycle, unless result is stalled, once their
// instruction is kept; a kept word is first committed in the ring and then registered into result.
// Up to seven words of an undecided instruction are held in the ring.
// item_ready drops only while the ring is full. Reset is synchronous and empties it.
`default_nettype none
module spirv_nonuniform_stripper_top
  import spvns_pkg::*;
#(
  parameter int HEADER_WORDS  = HEADER_WORDS_DEF,
  parameter int PENDING_DEPTH = PENDING_DEPTH_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_ready,
  input  wire item_t   item,
  output logic         result_valid,
  input  wire logic    result_ready,
  output result_t      result
);

  localparam int RING_DEPTH = 2 ** $clog2(2 * PENDING_DEPTH);
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int PTR_W      = IDX_W + 1;
  localparam int HDR_W      = $clog2(HEADER_WORDS + 1);

  result_t ring [RING_DEPTH];

  logic [PTR_W-1:0] wr, wr_next;
  logic [PTR_W-1:0] cm, cm_next;
  logic [PTR_W-1:0] rd;
  logic [HDR_W-1:0] header_left, header_left_next;
  logic [15:0]      words_left, words_left_next;
  logic [15:0]      cur_opcode, cur_opcode_next;
  logic [15:0]      cur_count, cur_count_next;
  decision_t        decision, decision_next;
  logic             name_ok, name_ok_next;

  logic             fire, hdr, start, name_cmp, wen, load;
  logic [15:0]      cnt, op, wc, wl, wl_dec;
  decision_t        dec, judged, dec_eff;
  logic [PTR_W-1:0] pos, used;
  logic [IDX_W-1:0] waddr;
  result_t          wdata;

  assign used       = wr - rd;
  assign item_ready = (used != PTR_W'(RING_DEPTH));
  assign fire       = item_valid && item_ready;

  assign hdr      = (header_left != '0);
  assign start    = (words_left == '0);
  assign cnt      = (item.word[31:16] == 16'd0) ? 16'd1 : item.word[31:16];
  assign op       = start ? item.word[15:0] : cur_opcode;
  assign wc       = start ? cnt : cur_count;
  assign wl       = start ? cnt : words_left;
  assign wl_dec   = wl - 16'd1;
  assign dec      = start ? DEC_UNDECIDED : decision;
  assign pos      = wr - cm;
  assign name_cmp = (item.word == ext_name_word(pos[2:0] - 3'd1));

  always_comb begin
    judged = DEC_KEEP;
    case (op)
      OP_CAPABILITY: begin
        if (wc < 16'd2) judged = DEC_KEEP;
        else if (pos < PTR_W'(1)) judged = DEC_UNDECIDED;
        else if (item.word >= CAP_FIRST && item.word <= CAP_LAST) judged = DEC_DROP;
        else judged = DEC_KEEP;
      end
      OP_DECORATE, OP_DECORATE_ID: begin
        if (wc < 16'd3) judged = DEC_KEEP;
        else if (pos < PTR_W'(2)) judged = DEC_UNDECIDED;
        else if (item.word == DECOR_NONUNIFORM) judged = DEC_DROP;
        else judged = DEC_KEEP;
      end
      OP_MEMBER_DECORATE: begin
        if (wc < 16'd4) judged = DEC_KEEP;
        else if (pos < PTR_W'(3)) judged = DEC_UNDECIDED;
        else if (item.word == DECOR_NONUNIFORM) judged = DEC_DROP;
        else judged = DEC_KEEP;
      end
      OP_EXTENSION: begin
        if (wc != EXT_INST_WORDS) judged = DEC_KEEP;
        else if (pos < PTR_W'(7)) judged = DEC_UNDECIDED;
        else if (name_ok && name_cmp) judged = DEC_DROP;
        else judged = DEC_KEEP;
      end
      default: judged = DEC_KEEP;
    endcase
  end

  assign dec_eff = (dec == DEC_UNDECIDED) ? judged : dec;

  always_comb begin
    wr_next          = wr;
    cm_next          = cm;
    header_left_next = header_left;
    words_left_next  = words_left;
    cur_opcode_next  = cur_opcode;
    cur_count_next   = cur_count;
    decision_next    = decision;
    name_ok_next     = name_ok;
    wen              = 1'b0;
    waddr            = wr[IDX_W-1:0];
    wdata            = '{out_word: item.word, has_word: 1'b1, end_of_module: item.last};
    if (fire) begin
      if (hdr) begin
        wen              = 1'b1;
        wr_next          = wr + PTR_W'(1);
        cm_next          = wr + PTR_W'(1);
        header_left_next = header_left - HDR_W'(1);
      end else begin
        words_left_next = wl_dec;
        cur_opcode_next = op;
        cur_count_next  = wc;
        decision_next   = (wl_dec == 16'd0) ? DEC_UNDECIDED : dec_eff;
        name_ok_next    = (pos == PTR_W'(1)) ? name_cmp : (name_ok && name_cmp);
        if (dec_eff == DEC_KEEP || (dec_eff == DEC_UNDECIDED && item.last)) begin
          wen     = 1'b1;
          wr_next = wr + PTR_W'(1);
          cm_next = wr + PTR_W'(1);
        end else if (dec_eff == DEC_UNDECIDED) begin
          wen     = 1'b1;
          wr_next = wr + PTR_W'(1);
        end else begin
          wr_next = cm;
          if (item.last) begin
            wen     = 1'b1;
            waddr   = cm[IDX_W-1:0];
            wdata   = '{out_word: 32'd0, has_word: 1'b0, end_of_module: 1'b1};
            wr_next = cm + PTR_W'(1);
            cm_next = cm + PTR_W'(1);
          end
        end
      end
      if (item.last) begin
        header_left_next = HDR_W'(HEADER_WORDS);
        words_left_next  = '0;
        cur_opcode_next  = '0;
        decision_next    = DEC_UNDECIDED;
      end
    end
  end

  assign load = (!result_valid || result_ready) && (rd != cm);

  always_ff @(posedge clk) begin
    if (wen) begin
      ring[waddr] <= wdata;
    end
    if (load) begin
      result <= ring[rd[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr           <= '0;
      cm           <= '0;
      rd           <= '0;
      header_left  <= HDR_W'(HEADER_WORDS);
      words_left   <= '0;
      cur_opcode   <= '0;
      cur_count    <= '0;
      decision     <= DEC_UNDECIDED;
      name_ok      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      wr          <= wr_next;
      cm          <= cm_next;
      header_left <= header_left_next;
      words_left  <= words_left_next;
      cur_opcode  <= cur_opcode_next;
      cur_count   <= cur_count_next;
      decision    <= decision_next;
      name_ok     <= name_ok_next;
      if (load) begin
        rd           <= rd + PTR_W'(1);
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  a_ring_bound: assert property (@(posedge clk) disable iff (rst)
    (wr - rd) <= PTR_W'(RING_DEPTH))
    else $error("ring holds more entries than its depth");

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    (wr - cm) < PTR_W'(PENDING_DEPTH))
    else $error("too many undecided words held");

  a_read_behind_commit: assert property (@(posedge clk) disable iff (rst)
    (cm - rd) <= (wr - rd))
    else $error("read pointer passed the commit point");

  a_boundary_clean: assert property (@(posedge clk) disable iff (rst)
    (words_left == '0) |-> (wr == cm))
    else $error("undecided words left at an instruction boundary");

  a_marker_form: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.has_word) |-> (result.end_of_module && result.out_word == 32'd0))
    else $error("end-only marker malformed");

endmodule
`default_nettype wire
